@@ rtl/tcce_pkg.sv @@
// tcce_pkg: shared types, constants and color tables of the text console cursor engine
// used by tcce_front, tcce_back, the top level and the port checker
`timescale 1ns / 1ps

package tcce_pkg;

   // screen geometry
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);

   // fixed field widths
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;
   localparam int ATTR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int XW      = COL_W + 1;

   // character codes and cell constants
   localparam logic [CHAR_W-1:0]  CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0]  CH_NL      = 8'd10;
   localparam logic [XW-1:0]      TAB_STEP   = 8'd4;
   localparam logic [CELL_W-1:0]  SPACE_CELL = 16'h0020;
   localparam logic [COLOR_W-1:0] NCOLORS    = 4'd9;
   localparam logic [COLOR_W-1:0] COLOR_TRANSPARENT = 4'd0;

   // input queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_GLYPH,
      KIND_TAB,
      KIND_NEWLINE
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_DISPATCH,
      ST_READ,
      ST_WRITE
   } back_state_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOR_W-1:0]  text_color;
      logic [COLOR_W-1:0]  back_color;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   // text color code to foreground nibble
   function automatic logic [3:0] fg_nibble(input logic [COLOR_W-1:0] code);
      logic [3:0] nib;
      case (code)
         4'd2:    nib = 4'hF;
         4'd3:    nib = 4'hC;
         4'd4:    nib = 4'hE;
         4'd5:    nib = 4'hA;
         4'd6:    nib = 4'hB;
         4'd7:    nib = 4'h9;
         4'd8:    nib = 4'hD;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

   // back color code to background nibble
   function automatic logic [3:0] bg_nibble(input logic [COLOR_W-1:0] code);
      logic [3:0] nib;
      case (code)
         4'd2:    nib = 4'h7;
         4'd3:    nib = 4'h4;
         4'd4:    nib = 4'h6;
         4'd5:    nib = 4'h2;
         4'd6:    nib = 4'h3;
         4'd7:    nib = 4'h1;
         4'd8:    nib = 4'h5;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

   // background nibble back to the first matching color code
   function automatic logic [COLOR_W-1:0] back_code_of(input logic [3:0] nib);
      logic [COLOR_W-1:0] code;
      case (nib)
         4'h7:    code = 4'd2;
         4'h4:    code = 4'd3;
         4'h6:    code = 4'd4;
         4'h2:    code = 4'd5;
         4'h3:    code = 4'd6;
         4'h1:    code = 4'd7;
         4'h5:    code = 4'd8;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   // attribute byte, zero when either code is out of the palette
   function automatic logic [ATTR_W-1:0] make_attr(input logic [COLOR_W-1:0] tc,
                                                   input logic [COLOR_W-1:0] bc);
      logic [ATTR_W-1:0] attr;
      if (tc >= NCOLORS || bc >= NCOLORS) begin
         attr = '0;
      end else begin
         attr = {bg_nibble(bc), fg_nibble(tc)};
      end
      return attr;
   endfunction

endpackage

@@ rtl/tcce_front.sv @@
// tcce_front: accepts request beats, classifies the character and queues the item
// depends on tcce_pkg; drained by tcce_back
`timescale 1ns / 1ps

module tcce_front
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [COLOR_W-1:0]  req_text_color,
   input  logic [COLOR_W-1:0]  req_back_color,
   input  back_status_type     back_status,
   output queue_head_type      head
);

   queue_item_type       q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   queue_item_type       new_item;
   logic                 push;
   logic                 pop;

   // classify the incoming character
   always_comb begin
      new_item.char_code  = req_char_code;
      new_item.text_color = req_text_color;
      new_item.back_color = req_back_color;
      case (req_char_code)
         CH_TAB:  new_item.kind = KIND_TAB;
         CH_NL:   new_item.kind = KIND_NEWLINE;
         default: new_item.kind = KIND_GLYPH;
      endcase
   end

   // no beat taken while full or while the screen store is being cleared
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = back_status.pop;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

endmodule

@@ rtl/tcce_back.sv @@
// tcce_back: cursor, screen store with row rotation, scroll clear and result register
// depends on tcce_pkg; takes items from tcce_front
`timescale 1ns / 1ps

module tcce_back
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      head,
   output back_status_type     back_status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cell_written,
   output logic [COL_W-1:0]    rsp_cell_col,
   output logic [ROW_W-1:0]    rsp_cell_row,
   output logic [ATTR_W-1:0]   rsp_cell_attr,
   output logic                rsp_scrolled,
   output logic [COL_W-1:0]    rsp_cursor_col,
   output logic [ROW_W-1:0]    rsp_cursor_row
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
   localparam logic [ROW_W:0]    ROWS_S    = (ROW_W + 1)'(ROWS);

   back_state_type       state_ff, state_in;
   logic [COL_W-1:0]     x_ff, x_in;
   logic [ROW_W-1:0]     y_ff, y_in;
   logic [ROW_W-1:0]     base_ff, base_in;
   logic                 scr_ff, scr_in;
   queue_item_type       item_ff, item_in;
   logic [ADDR_W-1:0]    sweep_addr_ff, sweep_addr_in;
   logic [COL_W-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [CELL_W-1:0]    rd_data_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_written_ff, out_written_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [ATTR_W-1:0]    out_attr_ff, out_attr_in;
   logic                 out_scr_ff, out_scr_in;
   logic [COL_W-1:0]     out_ccol_ff, out_ccol_in;
   logic [ROW_W-1:0]     out_crow_ff, out_crow_in;

   logic [CELL_W-1:0]    cells_mem [CELLS];
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [CELL_W-1:0]    mem_wd;

   logic                 pop;
   logic                 scroll_pending;
   logic                 sweep_row_done;
   logic [ROW_W:0]       row_sum;
   logic [ROW_W-1:0]     phys_row;
   logic [XW-1:0]        x_tab;
   logic [XW-1:0]        x_inc;
   logic [COLOR_W-1:0]   cur_back;
   logic [COLOR_W-1:0]   eff_text;
   logic [COLOR_W-1:0]   eff_back;
   logic [ATTR_W-1:0]    new_attr;

   // take the next item only when the result register is empty
   assign pop            = (state_ff == ST_IDLE) && head.valid && !out_valid_ff;
   assign scroll_pending = (y_ff >= ROW_W'(ROWS));
   assign sweep_row_done = (sweep_cnt_ff == COL_W'(COLS - 1));

   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign back_status.pop      = pop;

   // logical row to physical row of the rotated store
   assign row_sum  = {1'b0, y_ff} + {1'b0, base_ff};
   assign phys_row = (row_sum >= ROWS_S) ? ROW_W'(row_sum - ROWS_S) : ROW_W'(row_sum);

   assign x_tab = {1'b0, x_ff} + TAB_STEP;
   assign x_inc = {1'b0, x_ff} + XW'(1);

   // attribute from the cell's current background
   assign cur_back = back_code_of(rd_data_ff[CELL_W-1 -: 4]);
   assign eff_text = (item_ff.text_color == COLOR_TRANSPARENT) ? cur_back : item_ff.text_color;
   assign eff_back = (item_ff.back_color == COLOR_TRANSPARENT) ? cur_back : item_ff.back_color;
   assign new_attr = make_attr(eff_text, eff_back);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               state_in = scroll_pending ? ST_SCROLL : ST_DISPATCH;
            end
         end
         ST_SCROLL: begin
            if (sweep_row_done) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = (item_ff.kind == KIND_GLYPH) ? ST_READ : ST_IDLE;
         end
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath, store writes and result register
   always_comb begin
      x_in           = x_ff;
      y_in           = y_ff;
      base_in        = base_ff;
      scr_in         = scr_ff;
      item_in        = item_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      addr_in        = addr_ff;
      mem_we         = 1'b0;
      mem_wa         = sweep_addr_ff;
      mem_wd         = SPACE_CELL;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_written_in = out_written_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;
      out_attr_in    = out_attr_ff;
      out_scr_in     = out_scr_ff;
      out_ccol_in    = out_ccol_ff;
      out_crow_in    = out_crow_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (pop) begin
               item_in       = head.item;
               scr_in        = 1'b0;
               sweep_cnt_in  = '0;
               sweep_addr_in = ADDR_W'(base_ff) * COLS_A;
            end
         end
         ST_SCROLL: begin
            // blank the old top row, which becomes the new bottom row
            mem_we        = 1'b1;
            sweep_addr_in = sweep_addr_ff + 1'b1;
            sweep_cnt_in  = sweep_cnt_ff + 1'b1;
            if (sweep_row_done) begin
               base_in = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + 1'b1;
               y_in    = ROW_W'(ROWS - 1);
               scr_in  = 1'b1;
            end
         end
         ST_DISPATCH: begin
            addr_in = ADDR_W'(phys_row) * COLS_A + ADDR_W'(x_ff);
            if (item_ff.kind != KIND_GLYPH) begin
               if (item_ff.kind == KIND_NEWLINE || x_tab >= XW'(COLS)) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = COL_W'(x_tab);
               end
               out_valid_in   = 1'b1;
               out_written_in = 1'b0;
               out_col_in     = '0;
               out_row_in     = '0;
               out_attr_in    = '0;
               out_scr_in     = scr_ff;
               out_ccol_in    = x_in;
               out_crow_in    = y_in;
            end
         end
         ST_READ: begin
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = {new_attr, item_ff.char_code};
            if (x_inc >= XW'(COLS)) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = COL_W'(x_inc);
            end
            out_valid_in   = 1'b1;
            out_written_in = 1'b1;
            out_col_in     = x_ff;
            out_row_in     = y_ff;
            out_attr_in    = new_attr;
            out_scr_in     = scr_ff;
            out_ccol_in    = x_in;
            out_crow_in    = y_in;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         x_ff          <= '0;
         y_ff          <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scr_ff         <= scr_in;
      item_ff        <= item_in;
      sweep_cnt_ff   <= sweep_cnt_in;
      addr_ff        <= addr_in;
      out_written_ff <= out_written_in;
      out_col_ff     <= out_col_in;
      out_row_ff     <= out_row_in;
      out_attr_ff    <= out_attr_in;
      out_scr_ff     <= out_scr_in;
      out_ccol_ff    <= out_ccol_in;
      out_crow_ff    <= out_crow_in;
   end

   // screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= cells_mem[addr_ff];
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cell_written = out_written_ff;
   assign rsp_cell_col     = out_col_ff;
   assign rsp_cell_row     = out_row_ff;
   assign rsp_cell_attr    = out_attr_ff;
   assign rsp_scrolled     = out_scr_ff;
   assign rsp_cursor_col   = out_ccol_ff;
   assign rsp_cursor_row   = out_crow_ff;

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Character terminal engine, usage notes.
// Request channel (req_*): one beat carries a character byte and a text and back
// color code. Tab moves the cursor four columns or, past the last column, to the next
// row; newline moves it to the next row; any other byte goes to the cell under the cursor.
// Response channel (rsp_*): one beat per request with the written cell (if any),
// its attribute, a scroll flag and the cursor after the character.
// Path from request beat to response: the queue, then the sequencer's dispatch, store
// read and store write steps for a written character, or dispatch alone for tab or
// newline, then the response register. A character that finds the cursor below the last
// row first scrolls, which blanks one row of the store; rows rotate, nothing is copied.
// The sequencer takes no new character before the last one is through and its
// response has left the response register.
// A two-beat queue keeps taking requests while a response waits on rsp_stall; the
// sequencer starts the next character only once the response register is empty.
// Reset: cursor goes to the top left and the store's ROWS*COLS (2000) cells are swept
// to spaces with attribute zero, during which req_stall stays high.
// depends on tcce_pkg, tcce_front and tcce_back
`timescale 1ns / 1ps

module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [COLOR_W-1:0]  req_text_color,
   input  logic [COLOR_W-1:0]  req_back_color,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_cell_written,
   output logic [COL_W-1:0]    rsp_cell_col,
   output logic [ROW_W-1:0]    rsp_cell_row,
   output logic [ATTR_W-1:0]   rsp_cell_attr,
   output logic                rsp_scrolled,
   output logic [COL_W-1:0]    rsp_cursor_col,
   output logic [ROW_W-1:0]    rsp_cursor_row
);

   queue_head_type   head;
   back_status_type  back_status;

   // accept and classify
   tcce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_text_color (req_text_color),
      .req_back_color (req_back_color),
      .back_status    (back_status),
      .head           (head)
   );

   // cursor, screen store and response
   tcce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .back_status      (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_written (rsp_cell_written),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_attr    (rsp_cell_attr),
      .rsp_scrolled     (rsp_scrolled),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row)
   );

endmodule

@@ rtl/tcce_checker.sv @@
// tcce_checker: port-level assertions for the text console cursor engine
// depends on tcce_pkg; bound to text_console_cursor_engine
`timescale 1ns / 1ps

module tcce_checker
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_cell_written,
   input  logic [COL_W-1:0]    rsp_cell_col,
   input  logic [ROW_W-1:0]    rsp_cell_row,
   input  logic [ATTR_W-1:0]   rsp_cell_attr,
   input  logic                rsp_scrolled,
   input  logic [COL_W-1:0]    rsp_cursor_col,
   input  logic [ROW_W-1:0]    rsp_cursor_row
);

   // no response beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_attr)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_row))
      else $error("stalled response beat changed");

   // tab and newline report an empty cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cell_written |->
         rsp_cell_col == '0 && rsp_cell_row == '0 && rsp_cell_attr == '0)
      else $error("cell fields set without a written cell");

   // cursor stays on the screen, the row may sit one past the bottom
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_cursor_col} < (COL_W + 1)'(COLS)
         && rsp_cursor_row <= ROW_W'(ROWS))
      else $error("cursor off the screen");

   // a character written after a scroll lands on the bottom row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled && rsp_cell_written |-> rsp_cell_row == ROW_W'(ROWS - 1))
      else $error("scrolled character not on the bottom row");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (.*);

@@ tb/tb.sv @@
// tb: self-checking bench for the text console cursor engine, random character traffic
// with idle gaps on both channels; expected reports come from a screen and cursor tracker
// depends on tcce_pkg and text_console_cursor_engine
`timescale 1ns / 1ps

module tb
   import tcce_pkg::*;
();

   // palette code to attribute nibble
   localparam int PALETTE = 9;
   localparam logic [3:0] TEXT_NIB [PALETTE] =
      '{4'h0, 4'h0, 4'hF, 4'hC, 4'hE, 4'hA, 4'hB, 4'h9, 4'hD};
   localparam logic [3:0] BACK_NIB [PALETTE] =
      '{4'h0, 4'h0, 4'h7, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h5};

   localparam int RANDOM_CHARS = 1000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic              written;
      logic [COL_W-1:0]  cell_col;
      logic [ROW_W-1:0]  cell_row;
      logic [ATTR_W-1:0] attr;
      logic              scrolled;
      logic [COL_W-1:0]  cur_col;
      logic [ROW_W-1:0]  cur_row;
   } cell_report_type;

   // screen and cursor tracker, holds the reports still owed by the block
   class cursor_tracker;
      logic [CELL_W-1:0] screen [CELLS];
      int                col;
      int                row;
      cell_report_type   reports_due [$];
      int                failures;

      function new();
         col = 0;
         row = 0;
         failures = 0;
         foreach (screen[i]) screen[i] = SPACE_CELL;
      endfunction

      function void scroll_up();
         for (int i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
         for (int i = 0; i < COLS; i++) screen[(ROWS - 1) * COLS + i] = SPACE_CELL;
      endfunction

      // first back color code whose nibble matches, 0 when none does
      function int back_code(logic [3:0] nib);
         for (int i = 0; i < PALETTE; i++) begin
            if (BACK_NIB[i] == nib) return i;
         end
         return 0;
      endfunction

      function void note_char(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] tc,
                              logic [COLOR_W-1:0] bc);
         cell_report_type   r;
         int                x;
         int                y;
         int                idx;
         int                cb;
         int                t;
         int                b;
         logic [ATTR_W-1:0] a;
         r = '0;
         x = col;
         y = row;
         // pending scroll from the previous character
         if (y >= ROWS) begin
            scroll_up();
            y = ROWS - 1;
            r.scrolled = 1'b1;
         end
         if (x >= COLS) begin
            x = 0;
            y = y + 1;
            if (y >= ROWS) begin
               scroll_up();
               y = ROWS - 1;
               r.scrolled = 1'b1;
            end
         end
         if (ch == CH_TAB) begin
            x = x + int'(TAB_STEP);
         end else if (ch != CH_NL) begin
            // glyph: transparent codes take the cell's current background
            idx = y * COLS + x;
            cb = back_code(screen[idx][CELL_W-1:CELL_W-4]);
            t = (tc == COLOR_TRANSPARENT) ? cb : int'(tc);
            b = (bc == COLOR_TRANSPARENT) ? cb : int'(bc);
            a = (t >= PALETTE || b >= PALETTE) ? '0 : {BACK_NIB[b], TEXT_NIB[t]};
            screen[idx] = {a, ch};
            r.written  = 1'b1;
            r.cell_col = x[COL_W-1:0];
            r.cell_row = y[ROW_W-1:0];
            r.attr     = a;
            x = x + 1;
         end
         if (ch == CH_NL || x >= COLS) begin
            x = 0;
            y = y + 1;
         end
         col = x;
         row = y;
         r.cur_col = x[COL_W-1:0];
         r.cur_row = y[ROW_W-1:0];
         reports_due.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_report(cell_report_type got);
         cell_report_type want;
         if (reports_due.size() == 0) begin
            $error("response beat with no character outstanding");
            failures++;
            return;
         end
         want = reports_due.pop_front();
         compare_field("cell_written", want.written, got.written);
         compare_field("cell_col", want.cell_col, got.cell_col);
         compare_field("cell_row", want.cell_row, got.cell_row);
         compare_field("cell_attr", want.attr, got.attr);
         compare_field("scrolled", want.scrolled, got.scrolled);
         compare_field("cursor_col", want.cur_col, got.cur_col);
         compare_field("cursor_row", want.cur_row, got.cur_row);
      endfunction

      function int pending();
         return reports_due.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CHAR_W-1:0]  req_char_code = '0;
   logic [COLOR_W-1:0] req_text_color = '0;
   logic [COLOR_W-1:0] req_back_color = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_cell_written;
   logic [COL_W-1:0]   rsp_cell_col;
   logic [ROW_W-1:0]   rsp_cell_row;
   logic [ATTR_W-1:0]  rsp_cell_attr;
   logic               rsp_scrolled;
   logic [COL_W-1:0]   rsp_cursor_col;
   logic [ROW_W-1:0]   rsp_cursor_row;

   cursor_tracker tracker = new();
   int            chars_sent = 0;

   text_console_cursor_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_text_color   (req_text_color),
      .req_back_color   (req_back_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_written (rsp_cell_written),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_attr    (rsp_cell_attr),
      .rsp_scrolled     (rsp_scrolled),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row)
   );

   always #5ns clock = ~clock;

   // mostly palette codes, now and then an invalid one
   function automatic logic [COLOR_W-1:0] pick_color();
      if ($urandom_range(0, 9) == 0) return COLOR_W'($urandom_range(9, 15));
      return COLOR_W'($urandom_range(0, 8));
   endfunction

   // offer one request beat after a random gap, return once it is taken
   task automatic drive_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] tc,
                             input logic [COLOR_W-1:0] bc);
      int gap;
      gap = (chars_sent % 200 < 40) ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= ch;
      req_text_color <= tc;
      req_back_color <= bc;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.note_char(ch, tc, bc);
      chars_sent++;
   endtask

   // stimulus
   initial begin
      int kind;
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: code extremes, transparent and invalid colors, tab and newline
      drive_char(8'h00, 4'd1, 4'd1);
      drive_char(8'hFF, 4'd8, 4'd8);
      drive_char(8'h41, 4'd0, 4'd0);
      drive_char(8'h42, 4'd0, 4'd5);
      drive_char(8'h43, 4'd3, 4'd0);
      drive_char(8'h44, 4'd9, 4'd2);
      drive_char(8'h45, 4'd2, 4'd9);
      drive_char(8'h46, 4'd15, 4'd15);
      drive_char(CH_TAB, 4'd4, 4'd4);
      drive_char(8'h7F, 4'd6, 4'd3);
      drive_char(CH_NL, 4'd0, 4'd0);
      drive_char(CH_NL, 4'd15, 4'd15);
      drive_char(CH_TAB, 4'd15, 4'd0);
      drive_char(8'h80, 4'd7, 4'd6);

      // random: text lines, newline runs, tab runs across the edge, and noise
      while (chars_sent < RANDOM_CHARS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            len = $urandom_range(1, 90);
            repeat (len) begin
               if ($urandom_range(0, 11) == 0)
                  drive_char(CH_TAB, pick_color(), pick_color());
               else
                  drive_char(CHAR_W'($urandom_range(32, 126)), pick_color(), pick_color());
            end
            if ($urandom_range(0, 3) != 0) drive_char(CH_NL, pick_color(), pick_color());
         end else if (kind == 6) begin
            repeat ($urandom_range(1, 5)) drive_char(CH_NL, pick_color(), pick_color());
         end else if (kind == 7) begin
            repeat ($urandom_range(5, 25)) drive_char(CH_TAB, pick_color(), pick_color());
         end else begin
            repeat ($urandom_range(1, 8))
               drive_char(CHAR_W'($urandom()), COLOR_W'($urandom()), COLOR_W'($urandom()));
         end
      end
      req_valid <= 1'b0;

      // drain, then let a possible stray beat show up
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // response side: random stalls, two long hold-offs to back up the request queue
   initial begin
      int              gap;
      int              beats_seen;
      cell_report_type got;
      beats_seen = 0;
      wait (reset == 1'b0);
      forever begin
         if (beats_seen == 5 || beats_seen == 300)
            gap = HOLD_CYCLES;
         else
            gap = (beats_seen % 160 >= 120) ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.written  = rsp_cell_written;
         got.cell_col = rsp_cell_col;
         got.cell_row = rsp_cell_row;
         got.attr     = rsp_cell_attr;
         got.scrolled = rsp_scrolled;
         got.cur_col  = rsp_cursor_col;
         got.cur_row  = rsp_cursor_row;
         tracker.check_report(got);
         beats_seen++;
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
